// ===== rtl/cie_xy_to_rgb_defines.svh =====
// Assertion macros shared by the checking code of the converter.
`ifndef CIE_XY_TO_RGB_DEFINES_SVH
`define CIE_XY_TO_RGB_DEFINES_SVH

// A condition that must be followed by another one in the same cycle.
`define CXR_ASSERT_NOW(label, clk, rstn, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (expr)) \
        else $error("cxr check failed");

// A condition that must be followed by another one in the next cycle.
`define CXR_ASSERT_NEXT(label, clk, rstn, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (expr)) \
        else $error("cxr check failed");

`endif

// ===== rtl/cxr_pkg.sv =====
package cxr_pkg;

    // Drive level width and packed bus widths.
    localparam int LEVEL_BITS = 10;
    localparam int OUT_W      = ((3 * LEVEL_BITS + 7) / 8) * 8;
    localparam int DIV_STEPS  = 32;
    localparam int ACC_W      = 44;

    // Smallest y used as a divisor, 0.001 in chromaticity units.
    localparam logic [15:0] Y_MIN = 16'd66;

    // Matrix coefficients scaled by 4096.
    localparam int COEF_X [3] = '{13273, -3970, 228};
    localparam int COEF_Z [3] = '{-2042, 170, 4330};
    localparam logic signed [ACC_W-1:0] Y_TERM [3] = '{
        ACC_W'(-6296 * 65536), ACC_W'(7684 * 65536), ACC_W'(-836 * 65536)};

    // One classified chromaticity pair.
    typedef struct packed {
        logic [15:0] x;
        logic [15:0] ym;
        logic        zneg;
        logic [15:0] zmag;
    } item_t;

    // State of one restoring division: remainder and dividend/quotient word.
    typedef struct packed {
        logic [15:0] rem;
        logic [31:0] dq;
    } div_t;

    // One quotient bit of a restoring division.
    function automatic div_t div_step(div_t s, logic [15:0] dvs);
        logic [16:0] t;
        div_t        n;
        t = {s.rem, s.dq[31]};
        if (t >= {1'b0, dvs}) begin
            t    = t - {1'b0, dvs};
            n.dq = {s.dq[30:0], 1'b1};
        end else begin
            n.dq = {s.dq[30:0], 1'b0};
        end
        n.rem = t[15:0];
        return n;
    endfunction

    // Clamp a channel sum to 0..1.0 and scale it to the drive level.
    function automatic logic [LEVEL_BITS-1:0] to_level(logic signed [ACC_W-1:0] acc);
        logic [ACC_W-13:0]          sh;
        logic [16:0]                v;
        logic [LEVEL_BITS+16:0]     t;
        sh = acc[ACC_W-1:12];
        if (acc[ACC_W-1]) begin
            v = 17'd0;
        end else if (sh > (ACC_W-12)'(65536)) begin
            v = 17'd65536;
        end else begin
            v = sh[16:0];
        end
        t = {v, {LEVEL_BITS{1'b0}}} - (LEVEL_BITS+17)'(v);
        return t[LEVEL_BITS+15:16];
    endfunction

endpackage

// ===== rtl/cie_xy_to_rgb.sv =====
// CIE 1931 x,y chromaticity to linear sRGB drive levels, with luminance taken
// as 1.0. A pair can enter in every clock cycle while the output is not held.
// A result passes the front register, the queue, 32 divider stages and three
// matrix and scaling stages. Most of the pipeline is the two restoring dividers
// for x/y and z/y, which produce one quotient bit per stage. Inputs y below 66
// are treated as 66.
`include "cie_xy_to_rgb_defines.svh"

module cie_xy_to_rgb (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // chroma_x [15:0], chroma_y [31:16]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cxr_pkg::OUT_W-1:0]     m_tdata    // red_level, green_level, blue_level
);

    logic           fr_valid;
    logic           q_in_ready;
    cxr_pkg::item_t fr_item;
    logic           q_valid;
    logic           bk_ready;
    cxr_pkg::item_t q_item;

    // Front: clamps y and classifies the sign of z.
    cxr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .out_valid (fr_valid),
        .out_ready (q_in_ready),
        .out_item  (fr_item)
    );

    // Short queue between the front and the arithmetic pipeline.
    cxr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (q_in_ready),
        .in_item   (fr_item),
        .out_valid (q_valid),
        .out_ready (bk_ready),
        .out_item  (q_item)
    );

    // Back: division, matrix and level scaling.
    cxr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (q_valid),
        .in_ready (bk_ready),
        .in_item  (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // An accepted pair lands in the front register.
    `CXR_ASSERT_NEXT(a_front_loaded, aclk, aresetn, s_tvalid && s_tready, fr_valid)
    // The front keeps its pair while the queue is full.
    `CXR_ASSERT_NEXT(a_front_holds, aclk, aresetn, fr_valid && !q_in_ready, fr_valid)
    // The back is ready whenever the output register is empty.
    `CXR_ASSERT_NOW(a_back_ready, aclk, aresetn, !m_tvalid, bk_ready)

endmodule

// ===== rtl/cxr_front.sv =====
module cxr_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [31:0]    s_tdata,   // chroma_x [15:0], chroma_y [31:16]
    output logic           out_valid,
    input  logic           out_ready,
    output cxr_pkg::item_t out_item
);

    logic           vld_reg;
    cxr_pkg::item_t item_reg;
    cxr_pkg::item_t item_next;
    logic [15:0]    ym;
    logic signed [17:0] zs;

    assign s_tready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_item  = item_reg;

    // Clamp y and form the signed z term as sign and magnitude.
    always_comb begin
        ym = (s_tdata[31:16] < cxr_pkg::Y_MIN) ? cxr_pkg::Y_MIN : s_tdata[31:16];
        zs = 18'sd65535 - $signed({2'b00, s_tdata[15:0]}) - $signed({2'b00, ym});
        item_next.x    = s_tdata[15:0];
        item_next.ym   = ym;
        item_next.zneg = zs[17];
        item_next.zmag = zs[17] ? 16'(-zs) : zs[15:0];
    end

    // Holding register toward the queue.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (s_tready) begin
            vld_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== rtl/cxr_queue.sv =====
module cxr_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  cxr_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output cxr_pkg::item_t out_item
);

    cxr_pkg::item_t mem [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic           push;
    logic           pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Two-entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== rtl/cxr_back.sv =====
module cxr_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  cxr_pkg::item_t                  in_item,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cxr_pkg::OUT_W-1:0]       m_tdata   // red, green, blue levels
);

    localparam int N = cxr_pkg::DIV_STEPS;
    localparam int L = cxr_pkg::LEVEL_BITS;

    cxr_pkg::div_t      dx_reg [N];
    cxr_pkg::div_t      dz_reg [N];
    logic [15:0]        ym_reg [N];
    logic               zneg_reg [N];
    logic               dvld_reg [N];
    logic signed [cxr_pkg::ACC_W-1:0] px_reg [3];
    logic signed [cxr_pkg::ACC_W-1:0] pz_reg [3];
    logic               pvld_reg;
    logic signed [cxr_pkg::ACC_W-1:0] acc_reg [3];
    logic               avld_reg;
    logic [L-1:0]       lvl_reg [3];
    logic               ovld_reg;
    logic               ce;
    cxr_pkg::div_t      dx_init;
    cxr_pkg::div_t      dz_init;
    logic signed [26:0] bx;
    logic signed [26:0] bz;

    // The whole pipeline moves unless the output register is held.
    assign ce       = !ovld_reg || m_tready;
    assign in_ready = ce;
    assign m_tvalid = ovld_reg;
    assign m_tdata  = cxr_pkg::OUT_W'({lvl_reg[2], lvl_reg[1], lvl_reg[0]});

    assign dx_init = '{rem: 16'd0, dq: {in_item.x, 16'd0}};
    assign dz_init = '{rem: 16'd0, dq: {in_item.zmag, 16'd0}};

    // Quotients are below 2^26 because y is at least 66.
    assign bx = $signed({1'b0, dx_reg[N-1].dq[25:0]});
    assign bz = zneg_reg[N-1] ? -$signed({1'b0, dz_reg[N-1].dq[25:0]})
                              :  $signed({1'b0, dz_reg[N-1].dq[25:0]});

    // Two restoring dividers, one quotient bit per stage.
    always_ff @(posedge aclk) begin
        if (ce) begin
            dx_reg[0]   <= cxr_pkg::div_step(dx_init, in_item.ym);
            dz_reg[0]   <= cxr_pkg::div_step(dz_init, in_item.ym);
            ym_reg[0]   <= in_item.ym;
            zneg_reg[0] <= in_item.zneg;
            for (int k = 1; k < N; k++) begin
                dx_reg[k]   <= cxr_pkg::div_step(dx_reg[k-1], ym_reg[k-1]);
                dz_reg[k]   <= cxr_pkg::div_step(dz_reg[k-1], ym_reg[k-1]);
                ym_reg[k]   <= ym_reg[k-1];
                zneg_reg[k] <= zneg_reg[k-1];
            end
        end
    end

    // Matrix products, sums, and level scaling.
    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < 3; k++) begin
                px_reg[k]  <= cxr_pkg::ACC_W'($signed(16'(cxr_pkg::COEF_X[k])) * bx);
                pz_reg[k]  <= cxr_pkg::ACC_W'($signed(16'(cxr_pkg::COEF_Z[k])) * bz);
                acc_reg[k] <= px_reg[k] + pz_reg[k] + cxr_pkg::Y_TERM[k];
                lvl_reg[k] <= cxr_pkg::to_level(acc_reg[k]);
            end
        end
    end

    // Valid bits along the pipeline.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < N; k++) begin
                dvld_reg[k] <= 1'b0;
            end
            pvld_reg <= 1'b0;
            avld_reg <= 1'b0;
            ovld_reg <= 1'b0;
        end else if (ce) begin
            dvld_reg[0] <= in_valid;
            for (int k = 1; k < N; k++) begin
                dvld_reg[k] <= dvld_reg[k-1];
            end
            pvld_reg <= dvld_reg[N-1];
            avld_reg <= pvld_reg;
            ovld_reg <= avld_reg;
        end
    end

endmodule
